// ===== hw/rtl/ocp_pkg.sv =====
`default_nettype none

package ocp_pkg;

	// Default widths of the phase and of a coordinate.
	localparam int PHASE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 24;

	// Fixed field widths.
	localparam int DIST_BITS   = 20;
	localparam int STEP_BITS   = 13;
	localparam int ZOOM_BITS   = 16;
	localparam int HEIGHT_BITS = 16;
	localparam int LIMIT_BITS  = 14;
	localparam int KEY_COUNT   = 6;

	// Configuration port.
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 20;

	localparam logic [CFG_ADDR_BITS-1:0] REG_ANGLE_STEP   = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_ZOOM_STEP    = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT_OFFS  = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_LAT_LIMIT    = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_DISTANCE = 3'd4;

	// Register reset values.
	localparam logic [STEP_BITS-1:0]   ANGLE_STEP_RST   = 13'd910;
	localparam logic [ZOOM_BITS-1:0]   ZOOM_STEP_RST    = 16'd1787;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_OFFS_RST  = 16'd3840;
	localparam logic [LIMIT_BITS-1:0]  LAT_LIMIT_RST    = 14'd16202;
	localparam logic [DIST_BITS-1:0]   MAX_DISTANCE_RST = 20'd1048575;
	localparam logic [DIST_BITS-1:0]   DISTANCE_RST     = 20'd12800;

	// Sine polynomial coefficients and limits.
	localparam logic [16:0] SIN_C1      = 17'd4640;
	localparam logic [16:0] SIN_C2      = 17'd42047;
	localparam logic [16:0] SIN_C3      = 17'd102944;
	localparam logic [15:0] SIN_MAX     = 16'd32767;
	localparam logic [14:0] QUARTER_14  = 15'd16384;
	localparam logic [15:0] QUARTER_PH  = 16'd16384;

	// Multiplier widths.
	localparam int MUL_A_BITS = 21;
	localparam int MUL_B_BITS = 18;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int OFFS_BITS  = 21;

	// Datapath operations; each uses the shared multiplier once.
	typedef enum logic [2:0] {
		OP_U2,
		OP_P1,
		OP_P2,
		OP_R,
		OP_RAD,
		OP_DY,
		OP_DX,
		OP_DZ
	} op_t;

	// Angle slots of the sine results.
	localparam logic [1:0] ANG_SLAT = 2'd0;
	localparam logic [1:0] ANG_CLAT = 2'd1;
	localparam logic [1:0] ANG_SLON = 2'd2;
	localparam logic [1:0] ANG_CLON = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       mul_en;
		logic       wb_en;
		logic       load_out;
		op_t        op;
		logic [1:0] ang;
	} ocp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_full;
	} ocp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ocp_ctrl.sv =====
`default_nettype none

module ocp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ocp_pkg::ocp_sts_t sts,
	output ocp_pkg::ocp_cmd_t     cmd
);
	import ocp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_FINAL
	} state_t;

	state_t     state_q;
	op_t        op_q;
	logic [1:0] ang_q;

	assign in_ready = (state_q == ST_IDLE);

	// Commands follow the state directly.
	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && (state_q == ST_IDLE);
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.wb_en    = (state_q == ST_WB);
		cmd.load_out = (state_q == ST_FINAL) && !sts.out_full;
		cmd.op       = op_q;
		cmd.ang      = ang_q;
	end

	// Sequencer: four sine evaluations, then the four offset products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_U2;
			ang_q   <= ANG_SLAT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						op_q    <= OP_U2;
						ang_q   <= ANG_SLAT;
					end
				end
				ST_MUL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					// The last offset product ends the sequence.
					if (op_q == OP_DZ) begin
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_MUL;
					end
					unique case (op_q)
						OP_U2:  op_q <= OP_P1;
						OP_P1:  op_q <= OP_P2;
						OP_P2:  op_q <= OP_R;
						OP_R: begin
							if (ang_q == ANG_CLON) begin
								op_q <= OP_RAD;
							end else begin
								op_q  <= OP_U2;
								ang_q <= ang_q + 2'd1;
							end
						end
						OP_RAD: op_q <= OP_DY;
						OP_DY:  op_q <= OP_DX;
						OP_DX:  op_q <= OP_DZ;
						OP_DZ:  op_q <= OP_U2;
						default: op_q <= OP_U2;
					endcase
				end
				ST_FINAL: begin
					if (!sts.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ocp_dp.sv =====
`default_nettype none

module ocp_dp #(
	parameter int PHASE_BITS = ocp_pkg::PHASE_BITS_DEF,
	parameter int COORD_BITS = ocp_pkg::COORD_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [ocp_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  wire logic [ocp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  wire logic [ocp_pkg::KEY_COUNT-1:0]       keys,
	input  wire logic signed [COORD_BITS-1:0]        target_x,
	input  wire logic signed [COORD_BITS-1:0]        target_y,
	input  wire logic signed [COORD_BITS-1:0]        target_z,
	input  wire ocp_pkg::ocp_cmd_t                   cmd,
	output ocp_pkg::ocp_sts_t                        sts,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [COORD_BITS-1:0]             cam_x,
	output logic signed [COORD_BITS-1:0]             cam_y,
	output logic signed [COORD_BITS-1:0]             cam_z,
	output logic signed [COORD_BITS-1:0]             look_x,
	output logic signed [COORD_BITS-1:0]             look_y,
	output logic signed [COORD_BITS-1:0]             look_z
);
	import ocp_pkg::*;

	localparam int LW = ((PHASE_BITS > LIMIT_BITS) ? PHASE_BITS : LIMIT_BITS) + 2;
	localparam int SW = ((COORD_BITS > OFFS_BITS) ? COORD_BITS : OFFS_BITS) + 2;
	localparam logic signed [LW-1:0] HALF_MAX = LW'((2 ** (PHASE_BITS - 1)) - 1);
	localparam logic [PHASE_BITS-1:0] LAT_RST = PHASE_BITS'(2 ** (PHASE_BITS - 3));
	localparam logic [PHASE_BITS-1:0] LON_RST = PHASE_BITS'(2 ** (PHASE_BITS - 1));
	localparam logic signed [SW-1:0] SAT_HI =
		{{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO =
		{{(SW - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

	// Configuration registers.
	logic [STEP_BITS-1:0]   angle_step_q;
	logic [ZOOM_BITS-1:0]   zoom_step_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [LIMIT_BITS-1:0]  lat_limit_q;
	logic [DIST_BITS-1:0]   max_dist_q;

	// Orbit state.
	logic signed [PHASE_BITS-1:0] lat_q;
	logic [PHASE_BITS-1:0]        lon_q;
	logic [DIST_BITS-1:0]         dist_q;

	// Item payload and intermediate results.
	logic signed [COORD_BITS-1:0] tx_q;
	logic signed [COORD_BITS-1:0] tz_q;
	logic signed [SW-1:0]         ty_q;
	logic [15:0]                  u2_q;
	logic [16:0]                  p_q;
	logic signed [15:0]           trig_q [4];
	logic signed [OFFS_BITS-1:0]  rad_q;
	logic signed [OFFS_BITS-1:0]  dy_q;
	logic signed [OFFS_BITS-1:0]  dx_q;
	logic signed [OFFS_BITS-1:0]  dz_q;
	logic signed [PROD_BITS-1:0]  prod_q;
	logic                         out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q <= ANGLE_STEP_RST;
			zoom_step_q  <= ZOOM_STEP_RST;
			height_q     <= HEIGHT_OFFS_RST;
			lat_limit_q  <= LAT_LIMIT_RST;
			max_dist_q   <= MAX_DISTANCE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_ANGLE_STEP:   angle_step_q <= cfg_wdata[STEP_BITS-1:0];
				REG_ZOOM_STEP:    zoom_step_q  <= cfg_wdata[ZOOM_BITS-1:0];
				REG_HEIGHT_OFFS:  height_q     <= cfg_wdata[HEIGHT_BITS-1:0];
				REG_LAT_LIMIT:    lat_limit_q  <= cfg_wdata[LIMIT_BITS-1:0];
				REG_MAX_DISTANCE: max_dist_q   <= cfg_wdata[DIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Latitude: up clamps from above, down from below, in that order.
	logic signed [LW-1:0] lim_cfg;
	logic signed [LW-1:0] lim;
	logic signed [LW-1:0] step_l;
	logic signed [LW-1:0] la0;
	logic signed [LW-1:0] la_up;
	logic signed [LW-1:0] la1;
	logic signed [LW-1:0] la_dn;
	logic signed [LW-1:0] la2;

	always_comb begin
		lim_cfg = {{(LW - LIMIT_BITS){1'b0}}, lat_limit_q};
		lim     = (lim_cfg < HALF_MAX) ? lim_cfg : HALF_MAX;
		step_l  = {{(LW - STEP_BITS){1'b0}}, angle_step_q};
		la0     = {{(LW - PHASE_BITS){lat_q[PHASE_BITS-1]}}, lat_q};
		la_up   = la0 + step_l;
		la1     = keys[0] ? ((la_up >= lim) ? lim : la_up) : la0;
		la_dn   = la1 - step_l;
		la2     = keys[1] ? ((la_dn <= -lim) ? -lim : la_dn) : la1;
	end

	// Longitude wraps over one turn.
	logic [PHASE_BITS-1:0] step_p;
	logic [PHASE_BITS-1:0] lo1;
	logic [PHASE_BITS-1:0] lo2;

	always_comb begin
		step_p = PHASE_BITS'(angle_step_q);
		lo1    = keys[2] ? (lon_q + step_p) : lon_q;
		lo2    = keys[3] ? (lo1 - step_p) : lo1;
	end

	// Distance saturates at max_distance going out and at zero going in.
	logic [DIST_BITS:0]   d_sum;
	logic [DIST_BITS-1:0] d1;
	logic [DIST_BITS-1:0] d2;
	logic [DIST_BITS-1:0] zoom_d;

	always_comb begin
		zoom_d = {{(DIST_BITS - ZOOM_BITS){1'b0}}, zoom_step_q};
		d_sum  = {1'b0, dist_q} + {1'b0, zoom_d};
		if (keys[4]) begin
			d1 = (d_sum > {1'b0, max_dist_q}) ? max_dist_q : d_sum[DIST_BITS-1:0];
		end else begin
			d1 = dist_q;
		end
		d2 = keys[5] ? ((d1 > zoom_d) ? (d1 - zoom_d) : '0) : d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q  <= LAT_RST;
			lon_q  <= LON_RST;
			dist_q <= DISTANCE_RST;
		end else if (cmd.accept) begin
			lat_q  <= la2[PHASE_BITS-1:0];
			lon_q  <= lo2;
			dist_q <= d2;
		end
	end

	// Target capture, with the height offset added to y.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tx_q <= target_x;
			tz_q <= target_z;
			ty_q <= {{(SW - COORD_BITS){target_y[COORD_BITS-1]}}, target_y}
				+ {{(SW - HEIGHT_BITS){1'b0}}, height_q};
		end
	end

	// Angles scaled to a 16-bit phase.
	logic [15:0] lat16;
	logic [15:0] lon16;

	generate
		if (PHASE_BITS >= 16) begin : g_ph_wide
			assign lat16 = lat_q[PHASE_BITS-1 -: 16];
			assign lon16 = lon_q[PHASE_BITS-1 -: 16];
		end else begin : g_ph_narrow
			assign lat16 = {lat_q, {(16 - PHASE_BITS){1'b0}}};
			assign lon16 = {lon_q, {(16 - PHASE_BITS){1'b0}}};
		end
	endgenerate

	// Fold the selected angle into the first quadrant.
	logic [15:0] ph;
	logic [1:0]  quad;
	logic [14:0] fold;
	logic [15:0] u;

	always_comb begin
		ph   = (cmd.ang[1] ? lon16 : lat16) + (cmd.ang[0] ? QUARTER_PH : 16'd0);
		quad = ph[15:14];
		fold = quad[0] ? (QUARTER_14 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
		u    = {fold, 1'b0};
	end

	// Shared multiplier operands.
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;

	always_comb begin
		unique case (cmd.op)
			OP_U2: begin
				mul_a = {{(MUL_A_BITS - 16){1'b0}}, u};
				mul_b = {{(MUL_B_BITS - 16){1'b0}}, u};
			end
			OP_P1: begin
				mul_a = {{(MUL_A_BITS - 16){1'b0}}, u2_q};
				mul_b = {{(MUL_B_BITS - 17){1'b0}}, SIN_C1};
			end
			OP_P2: begin
				mul_a = {{(MUL_A_BITS - 16){1'b0}}, u2_q};
				mul_b = {{(MUL_B_BITS - 17){1'b0}}, p_q};
			end
			OP_R: begin
				mul_a = {{(MUL_A_BITS - 16){1'b0}}, u};
				mul_b = {{(MUL_B_BITS - 17){1'b0}}, p_q};
			end
			OP_RAD: begin
				mul_a = {{(MUL_A_BITS - DIST_BITS){1'b0}}, dist_q};
				mul_b = {{(MUL_B_BITS - 16){trig_q[ANG_CLAT][15]}}, trig_q[ANG_CLAT]};
			end
			OP_DY: begin
				mul_a = {{(MUL_A_BITS - DIST_BITS){1'b0}}, dist_q};
				mul_b = {{(MUL_B_BITS - 16){trig_q[ANG_SLAT][15]}}, trig_q[ANG_SLAT]};
			end
			OP_DX: begin
				mul_a = rad_q;
				mul_b = {{(MUL_B_BITS - 16){trig_q[ANG_SLON][15]}}, trig_q[ANG_SLON]};
			end
			OP_DZ: begin
				mul_a = rad_q;
				mul_b = {{(MUL_B_BITS - 16){trig_q[ANG_CLON][15]}}, trig_q[ANG_CLON]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Product post-processing; the arithmetic shift rounds toward minus infinity.
	logic signed [PROD_BITS-1:0] prod_sh;
	logic [15:0]                 r_raw;
	logic [15:0]                 r_cap;
	logic signed [15:0]          sin_val;

	always_comb begin
		prod_sh = prod_q >>> 15;
		r_raw   = prod_q[31:16];
		r_cap   = (r_raw > SIN_MAX) ? SIN_MAX : r_raw;
		sin_val = quad[1] ? -$signed(r_cap) : $signed(r_cap);
	end

	always_ff @(posedge clk) begin
		if (cmd.wb_en) begin
			unique case (cmd.op)
				OP_U2:  u2_q <= prod_q[30:15];
				OP_P1:  p_q  <= SIN_C2 - {4'b0, prod_q[27:15]};
				OP_P2:  p_q  <= SIN_C3 - {1'b0, prod_q[30:15]};
				OP_R:   trig_q[cmd.ang] <= sin_val;
				OP_RAD: rad_q <= prod_sh[OFFS_BITS-1:0];
				OP_DY:  dy_q  <= prod_sh[OFFS_BITS-1:0];
				OP_DX:  dx_q  <= prod_sh[OFFS_BITS-1:0];
				OP_DZ:  dz_q  <= prod_sh[OFFS_BITS-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic signed [COORD_BITS-1:0] res;
		if (v > SAT_HI) begin
			res = SAT_HI[COORD_BITS-1:0];
		end else if (v < SAT_LO) begin
			res = SAT_LO[COORD_BITS-1:0];
		end else begin
			res = v[COORD_BITS-1:0];
		end
		return res;
	endfunction

	// Final sums, each formed wide and saturated once.
	logic signed [SW-1:0] tx_w;
	logic signed [SW-1:0] tz_w;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] sum_z;

	always_comb begin
		tx_w  = {{(SW - COORD_BITS){tx_q[COORD_BITS-1]}}, tx_q};
		tz_w  = {{(SW - COORD_BITS){tz_q[COORD_BITS-1]}}, tz_q};
		sum_x = tx_w + {{(SW - OFFS_BITS){dx_q[OFFS_BITS-1]}}, dx_q};
		sum_y = ty_q + {{(SW - OFFS_BITS){dy_q[OFFS_BITS-1]}}, dy_q};
		sum_z = tz_w + {{(SW - OFFS_BITS){dz_q[OFFS_BITS-1]}}, dz_q};
	end

	// Output register; it holds a result until the transfer completes.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cam_x  <= sat_coord(sum_x);
			cam_y  <= sat_coord(sum_y);
			cam_z  <= sat_coord(sum_z);
			look_x <= tx_q;
			look_y <= sat_coord(ty_q);
			look_z <= tz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_full = out_valid_q && !out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/orbit_camera_position_unit.sv =====
// Items are processed one at a time: a new input is taken only in the idle state,
// since the single shared multiplier runs twenty operations (four sine
// polynomials and four offset products) for each item. The output register lets
// the next item in while a result waits.
// Reset: arst_n clears the controller, the output valid, the orbit state
// (latitude 45 degrees, longitude 180 degrees, distance 50.0) and the configuration registers.
`default_nettype none

module orbit_camera_position_unit #(
	parameter int PHASE_BITS = ocp_pkg::PHASE_BITS_DEF,
	parameter int COORD_BITS = ocp_pkg::COORD_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Configuration write port.
	input  wire logic                                   cfg_wen,
	input  wire logic [ocp_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  wire logic [ocp_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	// Input stream.
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// key_up, key_down, key_left, key_right, zoom_out, zoom_in,
	// target_x, target_y, target_z
	input  wire logic [((ocp_pkg::KEY_COUNT + 3 * COORD_BITS + 7) / 8) * 8 - 1:0]
	                                                    s_axis_tdata,
	// Output stream.
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// cam_x, cam_y, cam_z, look_x, look_y, look_z
	output logic [((6 * COORD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
	import ocp_pkg::*;

	localparam int OUT_W = ((6 * COORD_BITS + 7) / 8) * 8;
	localparam int TX_LO = KEY_COUNT;
	localparam int TY_LO = KEY_COUNT + COORD_BITS;
	localparam int TZ_LO = KEY_COUNT + 2 * COORD_BITS;

	ocp_cmd_t cmd;
	ocp_sts_t sts;

	logic signed [COORD_BITS-1:0] cam_x;
	logic signed [COORD_BITS-1:0] cam_y;
	logic signed [COORD_BITS-1:0] cam_z;
	logic signed [COORD_BITS-1:0] look_x;
	logic signed [COORD_BITS-1:0] look_y;
	logic signed [COORD_BITS-1:0] look_z;

	ocp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ocp_dp #(
		.PHASE_BITS (PHASE_BITS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.keys      (s_axis_tdata[KEY_COUNT-1:0]),
		.target_x  (s_axis_tdata[TX_LO +: COORD_BITS]),
		.target_y  (s_axis_tdata[TY_LO +: COORD_BITS]),
		.target_z  (s_axis_tdata[TZ_LO +: COORD_BITS]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cam_x     (cam_x),
		.cam_y     (cam_y),
		.cam_z     (cam_z),
		.look_x    (look_x),
		.look_y    (look_y),
		.look_z    (look_z)
	);

	// Pack the result fields, cam_x in the lowest bits.
	assign m_axis_tdata = OUT_W'({look_z, look_y, look_x, cam_z, cam_y, cam_x});

`ifndef SYNTHESIS
	// A result is loaded only into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_full)
		else $error("result loaded over a pending output");

	// A loaded result is offered on the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_axis_tvalid)
		else $error("loaded result not offered");

	// After an input transfer the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	// Multiply and write-back never share a cycle.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_en && cmd.wb_en))
		else $error("multiply and write-back overlap");
`endif

endmodule

`default_nettype wire
